FILE: hdl/cds_pkg.sv
// Shared types, constants and table functions for the calendar date stepper.
// Used by cds_ctrl, cds_dp and calendar_date_stepper; depends on nothing else.
package cds_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 15;
  localparam int CENT_W  = 8;   // year / 100 for any 14-bit year
  localparam int YREM_W  = 7;   // year % 100
  localparam int WDAY_W  = 3;
  localparam int ZSUM_W  = 10;
  localparam int PROD_W  = 27;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  LAST_YEAR = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

  // floor(y / 100) == (y * 5243) >> 19, exact for every y below 2**14.
  localparam logic [PROD_W-1:0] RECIP_100   = PROD_W'(5243);
  localparam int                RECIP_SHIFT = 19;

  // Keeps the weekday sum positive: a multiple of 7 larger than twice any century.
  localparam logic [ZSUM_W-1:0] ZELLER_BIAS = ZSUM_W'(329);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_CHECK,
    ST_STEP,
    ST_SUM,
    ST_OUT
  } cds_state_t;

  typedef struct packed {
    logic accept;    // capture the input item
    logic mul;       // year times the reciprocal of 100
    logic split;     // century and year-in-century from the product
    logic step;      // advance the held date by one day
    logic sat_set;   // advance stopped at the last representable date
    logic sum;       // register the weekday sum and the date flags
    logic out_load;  // load the result register
  } cds_cmd_t;

  typedef struct packed {
    logic date_ok;
    logic at_limit;
    logic count_zero;
  } cds_status_t;

  // Days in month m; a leap February has 29. Months outside 1..12 give 0.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // floor(13 * (mm + 1) / 5) for the shifted month mm of 3..14.
  function automatic logic [5:0] zeller_mterm(input logic [MONTH_W-1:0] mm);
    logic [5:0] t;
    case (mm)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/calendar_date_stepper.sv
// Top level of the calendar date stepper: stream ports, packing of the items,
// and the controller and datapath. Depends on cds_pkg, cds_ctrl and cds_dp.

// The block holds a Gregorian date, 1 January of year 1 after reset. Every input
// item gives exactly one result item. A load item (tuser 0) stores the given day,
// month and year as they are, valid or not, and then splits the year into century
// and year-in-century with a reciprocal multiplier, in the MUL and SPLIT states.
// An advance item (tuser 1) walks a valid date forward one day per cycle through
// the day counter; an invalid held date is returned unchanged. An advance that
// still has days left at 31 December 9999 stops there and reports saturated. Each
// result carries the date, its weekday (0 is Sunday, forced to 0 for an invalid
// date), and flags for a valid date, the last day of its month and the month of
// December. The block works on one item at a time; a finished result waits in
// the output register, and the next item is accepted while it waits.
module calendar_date_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // load_day[4:0], load_month[8:5], load_year[22:9], day_count[37:23], zero fill
  input  logic [cds_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op: 0 load, 1 advance
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cur_day[4:0], cur_month[8:5], cur_year[22:9], weekday[25:23], date_ok[26],
  // month_end[27], year_end_month[28], saturated[29], zero fill
  output logic [cds_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  cds_pkg::cds_cmd_t    cmd;
  cds_pkg::cds_status_t status;

  logic [cds_pkg::DAY_W-1:0]   cur_day;
  logic [cds_pkg::MONTH_W-1:0] cur_month;
  logic [cds_pkg::YEAR_W-1:0]  cur_year;
  logic [cds_pkg::WDAY_W-1:0]  weekday;
  logic                        date_ok;
  logic                        month_end;
  logic                        year_end_month;
  logic                        saturated;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_op          (s_axis_tuser),
    .load_day       (s_axis_tdata[4:0]),
    .load_month     (s_axis_tdata[8:5]),
    .load_year      (s_axis_tdata[22:9]),
    .day_count      (s_axis_tdata[37:23]),
    .cur_day        (cur_day),
    .cur_month      (cur_month),
    .cur_year       (cur_year),
    .weekday        (weekday),
    .date_ok        (date_ok),
    .month_end      (month_end),
    .year_end_month (year_end_month),
    .saturated      (saturated)
  );

  // The two fill bits of the input data word carry nothing and are left unread.
  assign m_axis_tdata = {2'b00, saturated, year_end_month, month_end, date_ok,
                         weekday, cur_year, cur_month, cur_day};

endmodule

FILE: hdl/cds_ctrl.sv
// Controller state machine of the calendar date stepper.
// Depends on cds_pkg; drives the command struct of cds_dp and owns the stream handshakes.
module cds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  output logic                out_valid,
  input  logic                out_ready,
  input  cds_pkg::cds_status_t status,
  output cds_pkg::cds_cmd_t    cmd
);

  cds_pkg::cds_state_t state, state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cds_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      cds_pkg::ST_IDLE: begin
        // Nothing is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = (in_op == cds_pkg::OP_LOAD) ? cds_pkg::ST_MUL : cds_pkg::ST_CHECK;
        end
      end
      cds_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = cds_pkg::ST_SPLIT;
      end
      cds_pkg::ST_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = cds_pkg::ST_SUM;
      end
      cds_pkg::ST_CHECK: begin
        state_next = status.date_ok ? cds_pkg::ST_STEP : cds_pkg::ST_SUM;
      end
      cds_pkg::ST_STEP: begin
        if (status.count_zero) begin
          state_next = cds_pkg::ST_SUM;
        end else if (status.at_limit) begin
          cmd.sat_set = 1'b1;
          state_next  = cds_pkg::ST_SUM;
        end else begin
          cmd.step = 1'b1;
        end
      end
      cds_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = cds_pkg::ST_OUT;
      end
      cds_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = cds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cds_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A held date that passed the validity check stays valid while it is walked.
  a_step_date_valid: assert property (@(posedge clk) disable iff (rst)
    (state == cds_pkg::ST_STEP) |-> status.date_ok)
    else $error("date became invalid during an advance");

  // The date never moves past the last representable day.
  a_no_step_at_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.at_limit)
    else $error("step issued at the upper date limit");

  // The result register is never overwritten while its item is still waiting.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  // An accepted item always leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != cds_pkg::ST_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule

FILE: hdl/cds_dp.sv
// Datapath of the calendar date stepper: held date, century split, day counter,
// weekday arithmetic and result register. Depends on cds_pkg; commanded by cds_ctrl.
module cds_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  cds_pkg::cds_cmd_t               cmd,
  output cds_pkg::cds_status_t            status,
  input  logic                           in_op,
  input  logic [cds_pkg::DAY_W-1:0]       load_day,
  input  logic [cds_pkg::MONTH_W-1:0]     load_month,
  input  logic [cds_pkg::YEAR_W-1:0]      load_year,
  input  logic [cds_pkg::COUNT_W-1:0]     day_count,
  output logic [cds_pkg::DAY_W-1:0]       cur_day,
  output logic [cds_pkg::MONTH_W-1:0]     cur_month,
  output logic [cds_pkg::YEAR_W-1:0]      cur_year,
  output logic [cds_pkg::WDAY_W-1:0]      weekday,
  output logic                           date_ok,
  output logic                           month_end,
  output logic                           year_end_month,
  output logic                           saturated
);

  // Held date, with the year also kept as century and year-in-century.
  logic [cds_pkg::DAY_W-1:0]   day_reg;
  logic [cds_pkg::MONTH_W-1:0] month_reg;
  logic [cds_pkg::YEAR_W-1:0]  year_reg;
  logic [cds_pkg::CENT_W-1:0]  cent;
  logic [cds_pkg::YREM_W-1:0]  yrem;
  logic [cds_pkg::COUNT_W-1:0] count;
  logic [cds_pkg::PROD_W-1:0]  prod;
  logic                        sat;

  // Registered weekday sum and date flags.
  logic [cds_pkg::ZSUM_W-1:0]  zsum;
  logic                        ok_q;
  logic                        mend_q;
  logic                        dec_q;

  logic                        leap;
  logic [cds_pkg::DAY_W-1:0]   mlen;
  logic                        ok;
  logic [cds_pkg::CENT_W-1:0]  cent_split;
  logic [cds_pkg::YEAR_W-1:0]  cent_x100;
  logic                        early;
  logic [cds_pkg::YREM_W-1:0]  zk;
  logic [cds_pkg::CENT_W-1:0]  zj;
  logic [cds_pkg::MONTH_W-1:0] zm;
  logic [cds_pkg::ZSUM_W-1:0]  zsum_next;
  logic [4:0]                  fold1;
  logic [3:0]                  fold2;
  logic [2:0]                  h;
  logic [cds_pkg::WDAY_W-1:0]  wday_next;

  assign leap = ((year_reg[1:0] == 2'b00) && (yrem != '0))
             || ((yrem == '0) && (cent[1:0] == 2'b00));
  assign mlen = cds_pkg::month_len(month_reg, leap);
  assign ok   = (mlen != '0) && (day_reg != '0) && (day_reg <= mlen)
             && (year_reg != '0) && (year_reg <= cds_pkg::LAST_YEAR);

  assign status.date_ok    = ok;
  assign status.at_limit   = (year_reg == cds_pkg::LAST_YEAR)
                          && (month_reg == cds_pkg::MONTH_DEC)
                          && (day_reg == cds_pkg::DAY_LAST);
  assign status.count_zero = (count == '0);

  assign cent_split = prod[cds_pkg::RECIP_SHIFT +: cds_pkg::CENT_W];
  assign cent_x100  = (cds_pkg::YEAR_W'(cent_split) << 6)
                    + (cds_pkg::YEAR_W'(cent_split) << 5)
                    + (cds_pkg::YEAR_W'(cent_split) << 2);

  // Zeller counts January and February as months 13 and 14 of the year before.
  assign early = (month_reg <= cds_pkg::MONTH_FEB);
  always_comb begin
    zk = yrem;
    zj = cent;
    zm = month_reg;
    if (early) begin
      zm = month_reg + cds_pkg::MONTH_W'(12);
      if (yrem == '0) begin
        zk = cds_pkg::YREM_W'(99);
        zj = cent - cds_pkg::CENT_W'(1);
      end else begin
        zk = yrem - cds_pkg::YREM_W'(1);
      end
    end
  end

  assign zsum_next = cds_pkg::ZSUM_W'(day_reg)
                   + cds_pkg::ZSUM_W'(cds_pkg::zeller_mterm(zm))
                   + cds_pkg::ZSUM_W'(zk)
                   + cds_pkg::ZSUM_W'(zk >> 2)
                   + cds_pkg::ZSUM_W'(zj >> 2)
                   + cds_pkg::ZELLER_BIAS
                   - (cds_pkg::ZSUM_W'(zj) << 1);

  // Modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  assign fold1 = 5'(zsum[2:0]) + 5'(zsum[5:3]) + 5'(zsum[8:6]) + 5'(zsum[9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign h     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  // Zeller gives 0 for Saturday; shift so that Sunday is 0.
  assign wday_next = (h == 3'd0) ? cds_pkg::WDAY_W'(6) : h - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= cds_pkg::DAY_W'(1);
      month_reg <= cds_pkg::MONTH_JAN;
      year_reg  <= cds_pkg::YEAR_W'(1);
      cent      <= '0;
      yrem      <= cds_pkg::YREM_W'(1);
      count     <= '0;
      sat       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        sat <= 1'b0;
        if (in_op == cds_pkg::OP_LOAD) begin
          day_reg   <= load_day;
          month_reg <= load_month;
          year_reg  <= load_year;
        end else begin
          count <= day_count;
        end
      end
      if (cmd.split) begin
        cent <= cent_split;
        yrem <= cds_pkg::YREM_W'(year_reg - cent_x100);
      end
      if (cmd.sat_set) begin
        sat <= 1'b1;
      end
      if (cmd.step) begin
        count <= count - cds_pkg::COUNT_W'(1);
        if (day_reg == mlen) begin
          day_reg <= cds_pkg::DAY_W'(1);
          if (month_reg == cds_pkg::MONTH_DEC) begin
            month_reg <= cds_pkg::MONTH_JAN;
            year_reg  <= year_reg + cds_pkg::YEAR_W'(1);
            if (yrem == cds_pkg::YREM_W'(99)) begin
              yrem <= '0;
              cent <= cent + cds_pkg::CENT_W'(1);
            end else begin
              yrem <= yrem + cds_pkg::YREM_W'(1);
            end
          end else begin
            month_reg <= month_reg + cds_pkg::MONTH_W'(1);
          end
        end else begin
          day_reg <= day_reg + cds_pkg::DAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= cds_pkg::PROD_W'(year_reg) * cds_pkg::RECIP_100;
    end
    if (cmd.sum) begin
      zsum   <= zsum_next;
      ok_q   <= ok;
      mend_q <= ok && (day_reg == mlen);
      dec_q  <= (month_reg == cds_pkg::MONTH_DEC);
    end
    if (cmd.out_load) begin
      cur_day        <= day_reg;
      cur_month      <= month_reg;
      cur_year       <= year_reg;
      weekday        <= ok_q ? wday_next : '0;
      date_ok        <= ok_q;
      month_end      <= mend_q;
      year_end_month <= dec_q;
      saturated      <= sat;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for calendar_date_stepper: drives load and advance items,
// predicts every result with its own calendar arithmetic and checks each one.
// Depends on cds_pkg and the calendar_date_stepper RTL.
module testbench;
  import cds_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 150000;
  localparam int DRAIN_CYCLES = 40;

  // One result item, split into its fields.
  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WDAY_W-1:0]  weekday;
    logic               ok;
    logic               month_end;
    logic               december;
    logic               saturated;
  } date_result_t;

  // Keeps its own copy of the held date and a queue of the results still owed.
  class date_scoreboard;
    date_result_t    owed[$];
    bit [DAY_W-1:0]   day;
    bit [MONTH_W-1:0] month;
    bit [YEAR_W-1:0]  year;
    int               errors;

    function new();
      day = 1;
      month = 1;
      year = 1;
      errors = 0;
    endfunction

    static function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int days_in_month(int m, int y);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return is_leap(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    static function bit is_valid(int d, int m, int y);
      return (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in_month(m, y)) &&
             (y >= 1) && (y <= int'(LAST_YEAR));
    endfunction

    // Zeller's congruence with March as month 3; the century term is taken as +5j,
    // which equals -2j modulo 7 and keeps the sum positive.
    static function int day_of_week(int d, int m, int y);
      int mm;
      int yy;
      int k;
      int j;
      int h;
      mm = m;
      yy = y;
      if (mm <= 2) begin
        mm += 12;
        yy -= 1;
      end
      k = yy % 100;
      j = yy / 100;
      h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      return (h + 6) % 7;
    endfunction

    function void next_day();
      if (day == days_in_month(month, year)) begin
        day = 1;
        if (month == MONTH_DEC) begin
          month = 1;
          year = year + YEAR_W'(1);
        end else begin
          month = month + MONTH_W'(1);
        end
      end else begin
        day = day + DAY_W'(1);
      end
    endfunction

    // Applies one accepted item to the held date and queues the result it owes.
    function void note_item(bit op, bit [DAY_W-1:0] d, bit [MONTH_W-1:0] m,
                            bit [YEAR_W-1:0] y, bit [COUNT_W-1:0] cnt);
      date_result_t r;
      bit           sat;
      bit           ok;
      sat = 1'b0;
      if (op == OP_LOAD) begin
        day = d;
        month = m;
        year = y;
      end else if (is_valid(day, month, year)) begin
        for (int i = 0; i < int'(cnt); i++) begin
          if (year == LAST_YEAR && month == MONTH_DEC && day == DAY_LAST) begin
            sat = 1'b1;
            break;
          end
          next_day();
        end
      end
      ok = is_valid(day, month, year);
      r.day       = day;
      r.month     = month;
      r.year      = year;
      r.weekday   = ok ? WDAY_W'(day_of_week(day, month, year)) : '0;
      r.ok        = ok;
      r.month_end = ok && (day == days_in_month(month, year));
      r.december  = (month == MONTH_DEC);
      r.saturated = sat;
      owed.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, logic [15:0] got);
      if (got !== 16'(want)) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      date_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with none expected, got data %h", $time, data);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("cur_day",        want.day,       16'(data[4:0]));
      compare_field("cur_month",      want.month,     16'(data[8:5]));
      compare_field("cur_year",       want.year,      16'(data[22:9]));
      compare_field("weekday",        want.weekday,   16'(data[25:23]));
      compare_field("date_ok",        want.ok,        16'(data[26]));
      compare_field("month_end",      want.month_end, 16'(data[27]));
      compare_field("year_end_month", want.december,  16'(data[28]));
      compare_field("saturated",      want.saturated, 16'(data[29]));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  date_scoreboard sb = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;
  // While set, neither side inserts gaps.
  bit calm = 1'b0;
  // Item counts with bit 14 set are slow, so only a few are allowed.
  int big_left = 6;
  int idle_cycles = 0;

  calendar_date_stepper i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Day counts are mostly small; each advance of a valid date costs one cycle per day.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 40);
    if (r < 85) return $urandom_range(41, 400);
    if (r < 97) return $urandom_range(401, 3000);
    if (big_left > 0) begin
      big_left--;
      return $urandom_range(16384, 32767);
    end
    return $urandom_range(3001, 8000);
  endfunction

  // A valid date, weighted toward the last years, century years and month ends.
  task automatic pick_valid_date(output bit [DAY_W-1:0] d, output bit [MONTH_W-1:0] m,
                                 output bit [YEAR_W-1:0] y);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 15) y = YEAR_W'($urandom_range(9990, 9999));
    else if (r < 30) y = YEAR_W'(100 * $urandom_range(1, 99));
    else y = YEAR_W'($urandom_range(1, 9999));
    r = $urandom_range(0, 99);
    if (r < 20) m = MONTH_FEB;
    else if (r < 35) m = MONTH_DEC;
    else m = MONTH_W'($urandom_range(1, 12));
    len = date_scoreboard::days_in_month(m, y);
    if ($urandom_range(0, 99) < 40) d = DAY_W'($urandom_range(len - 2, len));
    else d = DAY_W'($urandom_range(1, len));
  endtask

  // Offers one item and returns at the falling edge after it was taken. The valid
  // is lowered only when a gap comes first, so it never toggles within one step.
  task automatic send_item(bit op, bit [DAY_W-1:0] d, bit [MONTH_W-1:0] m,
                           bit [YEAR_W-1:0] y, bit [COUNT_W-1:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, cnt, y, m, d};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, d, m, y, cnt);
    @(negedge clk);
  endtask

  task automatic send_load(int d, int m, int y);
    send_item(OP_LOAD, DAY_W'(d), MONTH_W'(m), YEAR_W'(y), COUNT_W'($urandom));
  endtask

  task automatic send_advance(int cnt);
    send_item(OP_ADVANCE, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom),
              COUNT_W'(cnt));
  endtask

  // Receiver: random stretches of ready and of stall, plus one long hold-off
  // whenever the stimulus asks for it.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Results are checked at the rising edge at which they are taken.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // Ends a hung run: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int  sent;
    int  r;
    int  n;
    bit  hold_early;
    bit  hold_late;
    bit [DAY_W-1:0]   d;
    bit [MONTH_W-1:0] m;
    bit [YEAR_W-1:0]  y;

    sent = 0;
    hold_early = 1'b0;
    hold_late = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The first items see the reset date, 1 January of year 1.
    send_advance(0);
    send_advance(365);
    send_load(28, 2, 1900);      // century year that is not a leap year
    send_advance(1);
    send_load(28, 2, 2000);      // century year divisible by 400 is a leap year
    send_advance(1);
    send_advance(1);
    send_load(28, 2, 2024);
    send_advance(2);
    send_load(31, 12, 1999);     // year rollover
    send_advance(1);
    send_load(31, 12, 9999);     // already at the last date: a zero count does not saturate
    send_advance(0);
    send_advance(1);
    send_load(25, 12, 9999);     // ends exactly on the last date without saturating
    send_advance(6);
    send_load(25, 12, 9999);
    send_advance(32767);
    send_load(31, 4, 2000);      // day past the end of its month: advance leaves it alone
    send_advance(5);
    send_load(29, 2, 2100);
    send_load(0, 1, 2000);
    send_load(31, 15, 16383);    // every load field at its top value
    send_load(1, 1, 0);          // year zero
    send_load(0, 0, 0);
    send_load(1, 1, 1);
    send_advance(32767);

    // Random part: mostly a valid load followed by a few advances, with some
    // broken loads and bare advances on whatever date is held.
    while (sent < ITEM_TARGET) begin
      if (sent >= 300 && !hold_early) begin
        hold_early = 1'b1;
        hold_req = 1'b1;
      end
      if (sent >= 1000 && !hold_late) begin
        hold_late = 1'b1;
        hold_req = 1'b1;
      end
      calm = ($urandom_range(0, 99) < 8);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        pick_valid_date(d, m, y);
        send_item(OP_LOAD, d, m, y, COUNT_W'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) send_advance(pick_count());
        sent += n + 1;
      end else if (r < 90) begin
        send_item(OP_LOAD, DAY_W'($urandom), MONTH_W'($urandom),
                  YEAR_W'($urandom), COUNT_W'($urandom));
        send_advance(pick_count());
        sent += 2;
      end else begin
        send_advance(pick_count());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
